// File: hdl/udptpc_pkg.sv
package udptpc_pkg;

  localparam logic [15:0] MAX_LEN_RESET = 16'd100;
  localparam logic [30:0] CNT_MAX       = 31'h7fff_ffff;
  localparam logic [31:0] SEQ_END       = 32'hffff_ffff;
  localparam logic [15:0] SUM_EMPTY     = 16'hffff;
  localparam logic [15:0] SEQ_BYTES     = 16'd4;
  localparam logic [15:0] HDR_BYTES     = 16'd2;

  // how many sequence bytes a packet kept, four or more folded into one code
  typedef enum logic [2:0] {
    KEPT_NONE  = 3'd0,
    KEPT_ONE   = 3'd1,
    KEPT_TWO   = 3'd2,
    KEPT_THREE = 3'd3,
    KEPT_FULL  = 3'd4
  } kept_t;

  // per-packet summary handed from the byte front end to the checker
  typedef struct packed {
    logic [15:0] sum;
    logic        pend_vld;
    logic [7:0]  pend_byte;
    logic [15:0] tail;
    logic [31:0] seq_shift;
    kept_t       kept;
  } pkt_desc_t;

endpackage

// File: hdl/udptpc_front.sv
module udptpc_front
  import udptpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_packet_len,
  input  logic        byte_vld,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        desc_vld,
  output pkt_desc_t   desc
);

  logic [15:0] max_len_r;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  logic [7:0]  pend_byte_r, pend_byte_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic        keep;
  logic [16:0] sum_add;

  assign cfg_ready = 1'b1;
  assign keep      = pos_r < max_len_r;
  // little-endian word: older body byte low, current body byte high
  assign sum_add   = {1'b0, sum_r} + {1'b0, tail_r[15:8], pend_byte_r};

  always_comb begin
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    pend_vld_nxt  = pend_vld_r;
    pend_byte_nxt = pend_byte_r;
    tail_nxt      = tail_r;
    seq_nxt       = seq_r;
    if (byte_vld && keep) begin
      if (pos_r >= HDR_BYTES) begin
        if (pend_vld_r) begin
          sum_nxt      = sum_add[15:0] + {15'd0, sum_add[16]};
          pend_vld_nxt = 1'b0;
        end else begin
          pend_vld_nxt  = 1'b1;
          pend_byte_nxt = tail_r[15:8];
        end
      end
      tail_nxt = {tail_r[7:0], data_byte};
      if (pos_r < SEQ_BYTES) begin
        seq_nxt = {seq_r[23:0], data_byte};
      end
      pos_nxt = pos_r + 16'd1;
    end

    desc_vld       = byte_vld && last_byte;
    desc.sum       = sum_nxt;
    desc.pend_vld  = pend_vld_nxt;
    desc.pend_byte = pend_byte_nxt;
    desc.tail      = tail_nxt;
    desc.seq_shift = seq_nxt;
    desc.kept      = (pos_nxt >= SEQ_BYTES) ? KEPT_FULL : kept_t'(pos_nxt[2:0]);

    // packet done, start clean
    if (byte_vld && last_byte) begin
      pos_nxt      = '0;
      sum_nxt      = '0;
      pend_vld_nxt = 1'b0;
      tail_nxt     = '0;
      seq_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= MAX_LEN_RESET;
      pos_r      <= '0;
      sum_r      <= '0;
      pend_vld_r <= 1'b0;
      tail_r     <= '0;
      seq_r      <= '0;
    end else begin
      if (cfg_valid) begin
        max_len_r <= cfg_max_packet_len;
      end
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      pend_vld_r <= pend_vld_nxt;
      tail_r     <= tail_nxt;
      seq_r      <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
  end

endmodule

// File: hdl/udptpc_fifo.sv
module udptpc_fifo
  import udptpc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pkt_desc_t wr_data,
  output logic      full,
  input  logic      pop,
  output pkt_desc_t rd_data,
  output logic      empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pkt_desc_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr, do_rd;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count over depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");

endmodule

// File: hdl/udptpc_back.sv
module udptpc_back
  import udptpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               desc_vld,
  input  pkt_desc_t          desc,
  output logic               desc_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic               out_checksum_ok,
  output logic               out_end_marker,
  output logic               out_runt_packet,
  output logic signed [31:0] out_sequence_number,
  output logic [15:0]        out_computed_checksum,
  output logic [15:0]        out_received_checksum,
  output logic [30:0]        out_success_count,
  output logic [30:0]        out_fail_count,
  output logic [30:0]        out_total_count,
  output logic [30:0]        out_expected_count
);

  // stage a: finish checksum, align sequence number
  logic        a_vld_r;
  logic        a_ok_r, a_endm_r, a_runt_r;
  logic [31:0] a_seq_r;
  logic [15:0] a_comp_r, a_recv_r;

  // stage b: counters and result
  logic        b_vld_r;
  logic [30:0] pass_r, fail_r, total_r;
  logic [31:0] high_r;

  logic        a_adv, b_adv;
  logic [16:0] fin_add;
  logic [15:0] fin_sum;
  logic        runt;
  logic [15:0] comp, recv;
  logic [31:0] seq;
  logic        ok;
  logic [30:0] pass_nxt, fail_nxt, total_nxt, exp_nxt;
  logic [31:0] high_nxt;

  function automatic logic [30:0] sat_inc(input logic [30:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 31'd1;
  endfunction

  assign b_adv    = a_vld_r && (!b_vld_r || out_pop);
  assign a_adv    = desc_vld && (!a_vld_r || b_adv);
  assign desc_pop = a_adv;
  assign out_empty = !b_vld_r;

  // odd trailing body byte forms a word with zero high half
  assign fin_add = {1'b0, desc.sum} + {9'd0, desc.pend_byte};

  always_comb begin
    fin_sum = desc.pend_vld ? (fin_add[15:0] + {15'd0, fin_add[16]}) : desc.sum;
    runt    = (desc.kept == KEPT_NONE) || (desc.kept == KEPT_ONE);
    comp    = runt ? SUM_EMPTY : ~fin_sum;
    recv    = runt ? 16'd0 : desc.tail;
    ok      = !runt && (comp == recv);
    case (desc.kept)
      KEPT_NONE:  seq = '0;
      KEPT_ONE:   seq = {desc.seq_shift[7:0], 24'd0};
      KEPT_TWO:   seq = {desc.seq_shift[15:0], 16'd0};
      KEPT_THREE: seq = {desc.seq_shift[23:0], 8'd0};
      KEPT_FULL:  seq = desc.seq_shift;
      default:    seq = desc.seq_shift;
    endcase
  end

  always_comb begin
    pass_nxt  = pass_r;
    fail_nxt  = fail_r;
    total_nxt = total_r;
    high_nxt  = high_r;
    if (!a_endm_r) begin
      if ($signed(a_seq_r) > $signed(high_r)) begin
        high_nxt = a_seq_r;
      end
      if (a_ok_r) begin
        pass_nxt = sat_inc(pass_r);
      end else begin
        fail_nxt = sat_inc(fail_r);
      end
      total_nxt = sat_inc(total_r);
    end
    exp_nxt = (!high_nxt[31] && (high_nxt[30:0] > total_nxt)) ? high_nxt[30:0] : total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      pass_r  <= '0;
      fail_r  <= '0;
      total_r <= '0;
      high_r  <= '0;
    end else begin
      if (a_adv) begin
        a_vld_r <= 1'b1;
      end else if (b_adv) begin
        a_vld_r <= 1'b0;
      end
      if (b_adv) begin
        b_vld_r <= 1'b1;
        pass_r  <= pass_nxt;
        fail_r  <= fail_nxt;
        total_r <= total_nxt;
        high_r  <= high_nxt;
      end else if (out_pop) begin
        b_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_ok_r   <= ok;
      a_endm_r <= seq == SEQ_END;
      a_runt_r <= runt;
      a_seq_r  <= seq;
      a_comp_r <= comp;
      a_recv_r <= recv;
    end
    if (b_adv) begin
      out_checksum_ok       <= a_ok_r;
      out_end_marker        <= a_endm_r;
      out_runt_packet       <= a_runt_r;
      out_sequence_number   <= a_seq_r;
      out_computed_checksum <= a_comp_r;
      out_received_checksum <= a_recv_r;
      out_success_count     <= pass_nxt;
      out_fail_count        <= fail_nxt;
      out_total_count       <= total_nxt;
      out_expected_count    <= exp_nxt;
    end
  end

  a_pass_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    pass_r <= total_r) else $error("success count above total");

  a_fail_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r <= total_r) else $error("fail count above total");

  a_endm_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_adv && a_endm_r |=> $stable(total_r) && $stable(high_r))
    else $error("end marker changed counters");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_pop && b_vld_r && !a_vld_r |=> !b_vld_r)
    else $error("result not released on pop");

endmodule

// File: hdl/udp_test_packet_checker.sv
// results pass the packet queue, stage a and stage b; throughput is one byte
//   per cycle while full is low and one result per cycle while pop is held,
//   set by the single 16-bit end-around add per byte in the front end
// full rises only when the packet queue holds QUEUE_DEPTH finished packets
// reset (rst_n low, synchronous) clears counters, packet state and queues;
//   max_packet_len returns to 100
module udp_test_packet_checker
  import udptpc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_max_packet_len,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               empty,
  input  logic               pop,
  output logic               out_checksum_ok,
  output logic               out_end_marker,
  output logic               out_runt_packet,
  output logic signed [31:0] out_sequence_number,
  output logic [15:0]        out_computed_checksum,
  output logic [15:0]        out_received_checksum,
  output logic [30:0]        out_success_count,
  output logic [30:0]        out_fail_count,
  output logic [30:0]        out_total_count,
  output logic [30:0]        out_expected_count
);

  logic      q_full, q_empty, q_pop;
  logic      byte_vld, desc_vld;
  pkt_desc_t desc_in, desc_out;

  assign full     = q_full;
  assign byte_vld = push && !q_full;

  udptpc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_packet_len (cfg_max_packet_len),
    .byte_vld           (byte_vld),
    .data_byte          (in_data_byte),
    .last_byte          (in_last_byte),
    .desc_vld           (desc_vld),
    .desc               (desc_in)
  );

  udptpc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (desc_vld),
    .wr_data (desc_in),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (desc_out),
    .empty   (q_empty)
  );

  udptpc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .desc_vld              (!q_empty),
    .desc                  (desc_out),
    .desc_pop              (q_pop),
    .out_pop               (pop),
    .out_empty             (empty),
    .out_checksum_ok       (out_checksum_ok),
    .out_end_marker        (out_end_marker),
    .out_runt_packet       (out_runt_packet),
    .out_sequence_number   (out_sequence_number),
    .out_computed_checksum (out_computed_checksum),
    .out_received_checksum (out_received_checksum),
    .out_success_count     (out_success_count),
    .out_fail_count        (out_fail_count),
    .out_total_count       (out_total_count),
    .out_expected_count    (out_expected_count)
  );

endmodule

// File: tb/udp_test_packet_checker_test.sv
module udp_test_packet_checker_test;
  import udptpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 8;
  localparam int PHASE_BYTES    = 240;
  localparam int MAX_WAIT       = 17;

  typedef struct packed {
    logic        ok;
    logic        endm;
    logic        runt;
    logic [31:0] seq;
    logic [15:0] computed;
    logic [15:0] received;
    logic [30:0] passed;
    logic [30:0] failed;
    logic [30:0] total;
    logic [30:0] expected;
  } pkt_report_t;

  typedef struct packed {
    logic [3:0]  len;
    logic [63:0] data;
    logic        typed;
    pkt_report_t rep;
  } dir_row_t;

  // short packets from reset: a runt, empty body, end marker, odd body, negative, top sequence
  localparam dir_row_t DIRECTED_ROWS [7] = '{
    '{4'd1, 64'hff00_0000_0000_0000, 1'b1,
      '{1'b0, 1'b0, 1'b1, 32'hff00_0000, 16'hffff, 16'h0000, 31'd0, 31'd1, 31'd1, 31'd1}},
    '{4'd2, 64'h0000_0000_0000_0000, 1'b1,
      '{1'b0, 1'b0, 1'b0, 32'h0000_0000, 16'hffff, 16'h0000, 31'd0, 31'd2, 31'd2, 31'd2}},
    '{4'd2, 64'hffff_0000_0000_0000, 1'b1,
      '{1'b1, 1'b0, 1'b0, 32'hffff_0000, 16'hffff, 16'hffff, 31'd1, 31'd2, 31'd3, 31'd3}},
    '{4'd6, 64'hffff_ffff_0000_0000, 1'b1,
      '{1'b1, 1'b1, 1'b0, 32'hffff_ffff, 16'h0000, 16'h0000, 31'd1, 31'd2, 31'd3, 31'd3}},
    '{4'd7, 64'h0000_0005_12fa_ed00, 1'b0, '0},
    '{4'd3, 64'h8000_0100_0000_0000, 1'b0, '0},
    '{4'd4, 64'h7fff_ffff_0000_0000, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_max_packet_len = '0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         in_data_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic               out_checksum_ok;
  logic               out_end_marker;
  logic               out_runt_packet;
  logic signed [31:0] out_sequence_number;
  logic [15:0]        out_computed_checksum;
  logic [15:0]        out_received_checksum;
  logic [30:0]        out_success_count;
  logic [30:0]        out_fail_count;
  logic [30:0]        out_total_count;
  logic [30:0]        out_expected_count;

  udp_test_packet_checker i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_packet_len   (cfg_max_packet_len),
    .push                 (push),
    .full                 (full),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .empty                (empty),
    .pop                  (pop),
    .out_checksum_ok      (out_checksum_ok),
    .out_end_marker       (out_end_marker),
    .out_runt_packet      (out_runt_packet),
    .out_sequence_number  (out_sequence_number),
    .out_computed_checksum(out_computed_checksum),
    .out_received_checksum(out_received_checksum),
    .out_success_count    (out_success_count),
    .out_fail_count       (out_fail_count),
    .out_total_count      (out_total_count),
    .out_expected_count   (out_expected_count)
  );

  always #5 clk = ~clk;

  // checker state mirror
  logic [15:0]        len_limit = MAX_LEN_RESET;
  logic [15:0]        fold_sum = '0;
  logic [15:0]        kept_count = '0;
  logic [15:0]        tail_bytes = '0;
  logic [7:0]         odd_byte = '0;
  logic               odd_valid = 1'b0;
  logic [31:0]        seq_bytes = '0;
  logic [30:0]        passed_n = '0;
  logic [30:0]        failed_n = '0;
  logic [30:0]        counted_n = '0;
  logic signed [31:0] top_seq = '0;

  pkt_report_t pending_reports[$];
  pkt_report_t typed_rep;
  bit          typed_next = 1'b0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;
  int          mismatches = 0;
  int          bytes_taken = 0;
  int          quiet_cycles = 0;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic bit predict_report(input logic [7:0] b, input logic fin,
                                        output pkt_report_t rep);
    logic [31:0] seq;
    int          kept;
    rep = '0;
    if (kept_count < len_limit) begin
      if (kept_count >= HDR_BYTES) begin
        if (odd_valid) begin
          fold_sum  = ones_add(fold_sum, {tail_bytes[15:8], odd_byte});
          odd_valid = 1'b0;
        end else begin
          odd_byte  = tail_bytes[15:8];
          odd_valid = 1'b1;
        end
      end
      tail_bytes = {tail_bytes[7:0], b};
      if (kept_count < SEQ_BYTES) seq_bytes = {seq_bytes[23:0], b};
      kept_count++;
    end
    if (!fin) return 1'b0;
    kept = int'(kept_count);
    if (kept == 0) seq = '0;
    else if (kept >= 4) seq = seq_bytes;
    else seq = seq_bytes << (8 * (4 - kept));
    rep.runt = kept_count < HDR_BYTES;
    if (rep.runt) begin
      rep.computed = SUM_EMPTY;
      rep.received = '0;
      rep.ok       = 1'b0;
    end else begin
      if (odd_valid) fold_sum = ones_add(fold_sum, {8'h00, odd_byte});
      rep.computed = ~fold_sum;
      rep.received = tail_bytes;
      rep.ok       = rep.computed == rep.received;
    end
    rep.seq  = seq;
    rep.endm = seq == SEQ_END;
    if (!rep.endm) begin
      if ($signed(seq) > top_seq) top_seq = seq;
      if (rep.ok) passed_n = (passed_n == CNT_MAX) ? passed_n : passed_n + 31'd1;
      else failed_n = (failed_n == CNT_MAX) ? failed_n : failed_n + 31'd1;
      counted_n = (counted_n == CNT_MAX) ? counted_n : counted_n + 31'd1;
    end
    rep.passed   = passed_n;
    rep.failed   = failed_n;
    rep.total    = counted_n;
    rep.expected = counted_n;
    if (!top_seq[31] && top_seq[30:0] > counted_n) rep.expected = top_seq[30:0];
    fold_sum   = '0;
    kept_count = '0;
    tail_bytes = '0;
    odd_byte   = '0;
    odd_valid  = 1'b0;
    seq_bytes  = '0;
    return 1'b1;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int          gap;
    pkt_report_t rep;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push         <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_taken++;
    if (predict_report(b, fin, rep)) begin
      if (typed_next) begin
        pending_reports.push_back(typed_rep);
        typed_next = 1'b0;
      end else begin
        pending_reports.push_back(rep);
      end
    end
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] pkt[$]);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    cfg_valid          <= 1'b1;
    cfg_max_packet_len <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    len_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_packet();
    logic [7:0]  pkt[$];
    logic [7:0]  body[$];
    logic [31:0] seq;
    logic [15:0] acc;
    logic [15:0] cks;
    int          kind;
    int          body_len;
    bit          cut_tail;
    kind     = $urandom_range(0, 99);
    cut_tail = 1'b0;
    if (kind < 10) begin
      // noise
      repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom()));
    end else begin
      case ($urandom_range(0, 5))
        0, 1:    seq = $urandom_range(0, 500);
        2:       seq = {1'b0, 31'($urandom())};
        3:       seq = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        default: seq = $urandom();
      endcase
      if (kind < 16) seq = SEQ_END;
      if ($urandom_range(0, 9) == 0) body_len = 4 + $urandom_range(0, 120);
      else body_len = 4 + $urandom_range(0, 24);
      // overlong packet whose kept bytes still form a valid packet
      if (kind >= 85 && len_limit >= 16'd6 && len_limit <= 16'd60) begin
        body_len = int'(len_limit) - 2;
        cut_tail = 1'b1;
      end
      for (int i = 0; i < 4; i++) body.push_back(seq[31 - 8 * i -: 8]);
      while (body.size() < body_len) body.push_back(8'($urandom()));
      acc = '0;
      for (int i = 0; i < body.size(); i += 2) begin
        acc = ones_add(acc, {(i + 1 < body.size()) ? body[i + 1] : 8'h00, body[i]});
      end
      cks = ~acc;
      if (kind >= 75 && kind < 85) cks = 16'($urandom());
      pkt = body;
      pkt.push_back(cks[15:8]);
      pkt.push_back(cks[7:0]);
      if (cut_tail) repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom()));
    end
    send_packet(pkt);
  endtask

  initial begin
    logic [7:0]  pkt[$];
    logic [15:0] len_value;
    int          start;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_max_len(MAX_LEN_RESET);
    foreach (DIRECTED_ROWS[r]) begin
      pkt.delete();
      for (int i = 0; i < DIRECTED_ROWS[r].len; i++) begin
        pkt.push_back(DIRECTED_ROWS[r].data[63 - 8 * i -: 8]);
      end
      typed_next = DIRECTED_ROWS[r].typed;
      typed_rep  = DIRECTED_ROWS[r].rep;
      send_packet(pkt);
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       len_value = 16'd2;
        1:       len_value = 16'hffff;
        2:       len_value = 16'd3;
        3:       len_value = 16'd5;
        4:       len_value = 16'($urandom_range(6, 40));
        5:       len_value = MAX_LEN_RESET;
        6:       len_value = 16'($urandom_range(2, 65535));
        default: len_value = 16'($urandom_range(6, 16));
      endcase
      write_max_len(len_value);
      in_burst = ($urandom_range(0, 3) == 0);
      start    = bytes_taken;
      while (bytes_taken - start < PHASE_BYTES) send_random_packet();
    end
    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side
  initial begin
    int gap;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = draw_wait(out_burst);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    pkt_report_t want;
    if (rst_n && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        $error("result item with nothing expected");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("checksum_ok", want.ok, out_checksum_ok);
        compare_field("end_marker", want.endm, out_end_marker);
        compare_field("runt_packet", want.runt, out_runt_packet);
        compare_field("sequence_number", want.seq, out_sequence_number);
        compare_field("computed_checksum", want.computed, out_computed_checksum);
        compare_field("received_checksum", want.received, out_received_checksum);
        compare_field("success_count", want.passed, out_success_count);
        compare_field("fail_count", want.failed, out_fail_count);
        compare_field("total_count", want.total, out_total_count);
        compare_field("expected_count", want.expected, out_expected_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
